/* hdl/rrhc_pkg.sv */
// Package for the receive ring header check: result codes, item structs
// and fixed ring constants. No dependencies.
package rrhc_pkg;

    localparam int PAGE_BYTES   = 256;
    localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
    localparam int HEADER_BYTES = 4;

    localparam int STATUS_INTACT_BIT  = 0;
    localparam int STATUS_OVERRUN_BIT = 3;

    localparam logic [7:0]  START_PAGE_RST = 8'd64;
    localparam logic [7:0]  STOP_PAGE_RST  = 8'd128;
    localparam logic [10:0] MIN_LENGTH_RST = 11'd60;
    localparam logic [7:0]  BOUNDARY_RST   = STOP_PAGE_RST - 8'd1;

    // configuration register indexes
    localparam logic [1:0] CFG_START_PAGE = 2'd0;
    localparam logic [1:0] CFG_STOP_PAGE  = 2'd1;
    localparam logic [1:0] CFG_MIN_LENGTH = 2'd2;

    typedef enum logic [2:0] {
        ACT_EMPTY    = 3'd0,
        ACT_DELIVER  = 3'd1,
        ACT_BAD_LEN  = 3'd2,
        ACT_BAD_NEXT = 3'd3,
        ACT_OVERRUN  = 3'd4,
        ACT_SKIPPED  = 3'd5
    } action_t;

    typedef struct packed {
        logic [15:0] max_length;
        logic [15:0] header_count;
        logic [7:0]  header_next;
        logic [7:0]  header_status;
        logic [7:0]  current_page;
    } rx_item_t;

    typedef struct packed {
        action_t     action;
        logic [7:0]  packet_page;
        logic [15:0] payload_length;
        logic [15:0] first_address;
        logic [15:0] first_length;
        logic [15:0] second_length;
        logic [7:0]  boundary_next;
        logic [31:0] bytes_next;
        logic [15:0] errors_next;
    } eval_t;

endpackage

/* hdl/receive_ring_header_check.sv */
// Top level of the receive ring header check: ring registers, running
// totals and the result register. Uses rrhc_pkg, rrhc_in_stage, rrhc_eval.
//
//  channel  direction  handshake            payload
//  s_       in         s_tvalid / s_tready  s_tdata: one receive header item
//  m_       out        m_tvalid / m_tready  m_tuser: action, m_tdata: result
//  cfg_     in         cfg_we               cfg_index, cfg_wdata
//
// One item per cycle while the result side does not stall; an item passes from
// the s_ transfer through the input register, then through the check logic
// into the result register, where boundary and totals update too.
// Reset is synchronous: ring registers take their defaults, the boundary
// sits one below the stop page, totals clear, both stages empty.
// A stalled result holds both stages; s_tready drops only when they are full.
module receive_ring_header_check (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [7:0] current_page, [15:8] header_status, [23:16] header_next,
    // [39:24] header_count, [55:40] max_length
    input  logic [55:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [7:0] packet_page, [23:8] payload_length, [39:24] first_address,
    // [55:40] first_length, [71:56] second_length, [79:72] new_boundary,
    // [111:80] byte_total, [127:112] error_total
    output logic [127:0] m_tdata,
    // [2:0] action
    output logic [2:0]   m_tuser,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [10:0]  cfg_wdata
);

    logic               advance;
    logic               item_valid;
    rrhc_pkg::rx_item_t item;
    rrhc_pkg::eval_t    res;

    logic [7:0]  start_page_reg;
    logic [7:0]  stop_page_reg;
    logic [10:0] min_length_reg;
    logic [7:0]  boundary_reg;
    logic [31:0] rx_bytes_reg;
    logic [15:0] rx_errors_reg;
    logic        m_valid_reg;
    logic        m_valid_next;
    rrhc_pkg::eval_t out_reg;

    assign advance      = !m_valid_reg || m_tready;
    assign m_valid_next = advance ? item_valid : m_valid_reg;

    rrhc_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    rrhc_eval u_eval (
        .item       (item),
        .start_page (start_page_reg),
        .stop_page  (stop_page_reg),
        .min_length (min_length_reg),
        .boundary   (boundary_reg),
        .rx_bytes   (rx_bytes_reg),
        .rx_errors  (rx_errors_reg),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_page_reg <= rrhc_pkg::START_PAGE_RST;
            stop_page_reg  <= rrhc_pkg::STOP_PAGE_RST;
            min_length_reg <= rrhc_pkg::MIN_LENGTH_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                rrhc_pkg::CFG_START_PAGE: start_page_reg <= cfg_wdata[7:0];
                rrhc_pkg::CFG_STOP_PAGE:  stop_page_reg  <= cfg_wdata[7:0];
                rrhc_pkg::CFG_MIN_LENGTH: min_length_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            boundary_reg  <= rrhc_pkg::BOUNDARY_RST;
            rx_bytes_reg  <= '0;
            rx_errors_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            // commit ring state with the result it belongs to
            if (advance && item_valid) begin
                boundary_reg  <= res.boundary_next;
                rx_bytes_reg  <= res.bytes_next;
                rx_errors_reg <= res.errors_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && item_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.action;
    assign m_tdata  = {out_reg.errors_next, out_reg.bytes_next, out_reg.boundary_next,
                       out_reg.second_length, out_reg.first_length,
                       out_reg.first_address, out_reg.payload_length,
                       out_reg.packet_page};

endmodule

/* hdl/rrhc_in_stage.sv */
// Input register of the receive ring header check.
// Depends on rrhc_pkg for the item struct.
module rrhc_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [55:0]       s_tdata,
    input  logic              advance,
    output logic              item_valid,
    output rrhc_pkg::rx_item_t item
);

    logic               valid_reg;
    logic               valid_next;
    rrhc_pkg::rx_item_t item_reg;

    // free slot, or the held item moves on in this cycle
    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= rrhc_pkg::rx_item_t'(s_tdata);
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* hdl/rrhc_eval.sv */
// Header check and copy split for one receive ring item.
// Depends on rrhc_pkg for constants, codes and structs.
module rrhc_eval (
    input  rrhc_pkg::rx_item_t item,
    input  logic [7:0]         start_page,
    input  logic [7:0]         stop_page,
    input  logic [10:0]        min_length,
    input  logic [7:0]         boundary,
    input  logic [31:0]        rx_bytes,
    input  logic [15:0]        rx_errors,
    output rrhc_pkg::eval_t    res
);

    logic [7:0]  page_inc;
    logic [7:0]  page;
    logic        empty;
    logic        short_cnt;
    logic [15:0] len;
    logic        bad_len;
    logic        bad_next;
    logic        overrun;
    logic        intact;
    logic [15:0] addr;
    logic [15:0] limit;
    logic [16:0] end_sum;
    logic [15:0] errors_inc;
    logic [7:0]  next_page;
    logic [7:0]  wrap_page;

    assign page_inc  = boundary + 8'd1;
    assign page      = (page_inc == stop_page) ? start_page : page_inc;
    assign empty     = (page == item.current_page);
    assign short_cnt = item.header_count < 16'(rrhc_pkg::HEADER_BYTES);
    assign len       = short_cnt ? 16'd0
                                 : item.header_count - 16'(rrhc_pkg::HEADER_BYTES);
    assign bad_len   = short_cnt || (len < 16'(min_length)) || (len > item.max_length);
    assign bad_next  = (item.header_next < start_page) || (item.header_next >= stop_page);
    assign overrun   = item.header_status[rrhc_pkg::STATUS_OVERRUN_BIT];
    assign intact    = item.header_status[rrhc_pkg::STATUS_INTACT_BIT];

    assign addr    = (16'(page) << rrhc_pkg::PAGE_SHIFT) + 16'(rrhc_pkg::HEADER_BYTES);
    assign limit   = 16'(stop_page) << rrhc_pkg::PAGE_SHIFT;
    assign end_sum = {1'b0, addr} + {1'b0, len};

    assign errors_inc = (rx_errors == 16'hFFFF) ? rx_errors : rx_errors + 16'd1;

    // failed checks resume at the current page, a delivered or skipped packet at its next page
    assign next_page = (bad_len || bad_next || overrun) ? item.current_page
                                                        : item.header_next;
    assign wrap_page = (next_page == start_page) ? stop_page : next_page;

    always_comb begin
        res                = '0;
        res.packet_page    = page;
        res.boundary_next  = boundary;
        res.bytes_next     = rx_bytes;
        res.errors_next    = rx_errors;
        res.action         = rrhc_pkg::ACT_EMPTY;
        if (!empty) begin
            res.payload_length = len;
            res.bytes_next     = rx_bytes + 32'(len);
            res.boundary_next  = wrap_page - 8'd1;
            if (bad_len) begin
                res.action      = rrhc_pkg::ACT_BAD_LEN;
                res.errors_next = errors_inc;
            end else if (bad_next) begin
                res.action      = rrhc_pkg::ACT_BAD_NEXT;
                res.errors_next = errors_inc;
            end else if (overrun) begin
                res.action      = rrhc_pkg::ACT_OVERRUN;
                res.errors_next = errors_inc;
            end else if (intact) begin
                res.action        = rrhc_pkg::ACT_DELIVER;
                res.first_address = addr;
                // split the copy where the ring wraps
                if (addr >= limit) begin
                    res.first_length  = 16'd0;
                    res.second_length = len;
                end else if (end_sum > {1'b0, limit}) begin
                    res.first_length  = limit - addr;
                    res.second_length = len - (limit - addr);
                end else begin
                    res.first_length  = len;
                    res.second_length = 16'd0;
                end
            end else begin
                res.action = rrhc_pkg::ACT_SKIPPED;
            end
        end
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for receive_ring_header_check: a directed table and random
// header streams, each result checked against an in-bench ring predictor.
// Depends on rrhc_pkg and the RTL top level only.
module tb;

    // one output item as it travels on m_tdata, last field in the low bits
    typedef struct packed {
        logic [15:0] error_total;
        logic [31:0] byte_total;
        logic [7:0]  new_boundary;
        logic [15:0] second_length;
        logic [15:0] first_length;
        logic [15:0] first_address;
        logic [15:0] payload_length;
        logic [7:0]  packet_page;
    } ring_fields_t;

    typedef struct packed {
        rrhc_pkg::action_t action;
        ring_fields_t      f;
    } ring_verdict_t;

    // directed row: header fields, then the typed-in part of the verdict
    typedef struct packed {
        logic [7:0]        cur;
        logic [7:0]        status;
        logic [7:0]        nxt;
        logic [15:0]       count;
        logic [15:0]       maxlen;
        logic              typed;
        rrhc_pkg::action_t act;
        logic [7:0]        page;
        logic [7:0]        bnd;
    } header_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [55:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = rrhc_pkg::CFG_START_PAGE;
    logic [10:0]  cfg_wdata = '0;

    // predictor state and ring registers
    logic [7:0]  ring_start;
    logic [7:0]  ring_stop;
    logic [10:0] ring_min;
    logic [7:0]  bnd_now;
    logic [31:0] bytes_now;
    logic [15:0] errs_now;

    ring_verdict_t verdicts_due[$];
    ring_verdict_t due_now;
    ring_fields_t  seen;
    int            faults = 0;
    int            src_idle_pct = 0;
    int            sink_stall_pct = 0;
    int            hold_request = 0;
    int            hold_left = 0;

    header_row_t directed_rows [21] = '{
        '{8'd64, 8'h00, 8'd0, 16'd0, 16'd0, 1'b1, rrhc_pkg::ACT_EMPTY, 8'd64, 8'd127},
        '{8'd70, 8'h01, 8'd72, 16'd3, 16'd1514, 1'b1, rrhc_pkg::ACT_BAD_LEN, 8'd64, 8'd69},
        '{8'd80, 8'h01, 8'd72, 16'd64, 16'd1514, 1'b0, rrhc_pkg::ACT_DELIVER, 8'd0, 8'd0},
        '{8'd90, 8'h01, 8'd74, 16'd100, 16'd95, 1'b1, rrhc_pkg::ACT_BAD_LEN, 8'd72, 8'd89},
        '{8'd100, 8'h01, 8'd92, 16'd63, 16'd1514, 1'b1, rrhc_pkg::ACT_BAD_LEN, 8'd90, 8'd99},
        '{8'd110, 8'h01, 8'd63, 16'd64, 16'd1514, 1'b1, rrhc_pkg::ACT_BAD_NEXT, 8'd100, 8'd109},
        '{8'd120, 8'h01, 8'd128, 16'd64, 16'd1514, 1'b1, rrhc_pkg::ACT_BAD_NEXT, 8'd110, 8'd119},
        '{8'd125, 8'hFF, 8'd122, 16'd64, 16'd1514, 1'b1, rrhc_pkg::ACT_OVERRUN, 8'd120, 8'd124},
        '{8'd10, 8'hF6, 8'd127, 16'd64, 16'd1514, 1'b1, rrhc_pkg::ACT_SKIPPED, 8'd125, 8'd126},
        // split across the ring end
        '{8'd10, 8'h01, 8'd66, 16'd604, 16'd65535, 1'b0, rrhc_pkg::ACT_DELIVER, 8'd0, 8'd0},
        // next page equal to the start page
        '{8'd10, 8'hF7, 8'd64, 16'd64, 16'd1514, 1'b0, rrhc_pkg::ACT_DELIVER, 8'd0, 8'd0},
        '{8'd10, 8'h01, 8'd65, 16'd65535, 16'd65535, 1'b0, rrhc_pkg::ACT_DELIVER, 8'd0, 8'd0},
        '{8'd200, 8'h01, 8'd70, 16'd0, 16'd1514, 1'b1, rrhc_pkg::ACT_BAD_LEN, 8'd65, 8'd199},
        // payload starts past the ring end
        '{8'd5, 8'h01, 8'd70, 16'd100, 16'd1514, 1'b0, rrhc_pkg::ACT_DELIVER, 8'd0, 8'd0},
        '{8'd0, 8'h01, 8'd70, 16'd1, 16'd1514, 1'b1, rrhc_pkg::ACT_BAD_LEN, 8'd70, 8'd255},
        // boundary 255 wraps to read page 0
        '{8'd255, 8'h01, 8'd100, 16'd64, 16'd60, 1'b0, rrhc_pkg::ACT_DELIVER, 8'd0, 8'd0},
        '{8'd100, 8'h00, 8'd0, 16'd0, 16'd0, 1'b1, rrhc_pkg::ACT_EMPTY, 8'd100, 8'd99},
        '{8'd255, 8'h01, 8'd100, 16'd4, 16'd0, 1'b1, rrhc_pkg::ACT_BAD_LEN, 8'd100, 8'd254},
        '{8'd0, 8'h01, 8'd127, 16'd1518, 16'd1514, 1'b0, rrhc_pkg::ACT_DELIVER, 8'd0, 8'd0},
        '{8'd3, 8'h01, 8'd255, 16'd64, 16'd1514, 1'b1, rrhc_pkg::ACT_BAD_NEXT, 8'd127, 8'd2},
        '{8'd255, 8'h09, 8'd64, 16'd64, 16'd65535, 1'b1, rrhc_pkg::ACT_OVERRUN, 8'd3, 8'd254}
    };

    receive_ring_header_check DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    initial begin
        #(20_000_000);
        $display("== FAIL ==");
        $finish;
    end

    // Work out the verdict for one header and advance the ring state.
    function automatic ring_verdict_t ring_step(input rrhc_pkg::rx_item_t hdr);
        ring_verdict_t v;
        logic [7:0]    pg;
        logic [7:0]    nxt;
        logic [15:0]   len;
        logic [31:0]   limit;
        logic [31:0]   addr;
        logic          short_cnt;
        logic          counts_error;
        v = '0;
        len = '0;
        counts_error = 1'b0;
        pg = bnd_now + 8'd1;
        if (pg == ring_stop) pg = ring_start;
        if (pg == hdr.current_page) begin
            v.action = rrhc_pkg::ACT_EMPTY;
        end else begin
            short_cnt = hdr.header_count < 16'(rrhc_pkg::HEADER_BYTES);
            if (!short_cnt) len = hdr.header_count - 16'(rrhc_pkg::HEADER_BYTES);
            nxt = hdr.header_next;
            if (short_cnt || len < 16'(ring_min) || len > hdr.max_length) begin
                v.action = rrhc_pkg::ACT_BAD_LEN;
                counts_error = 1'b1;
            end else if (nxt < ring_start || nxt >= ring_stop) begin
                v.action = rrhc_pkg::ACT_BAD_NEXT;
                counts_error = 1'b1;
            end else if (hdr.header_status[rrhc_pkg::STATUS_OVERRUN_BIT]) begin
                v.action = rrhc_pkg::ACT_OVERRUN;
                counts_error = 1'b1;
            end else if (hdr.header_status[rrhc_pkg::STATUS_INTACT_BIT]) begin
                v.action = rrhc_pkg::ACT_DELIVER;
                limit = 32'(ring_stop) * rrhc_pkg::PAGE_BYTES;
                addr = 32'(pg) * rrhc_pkg::PAGE_BYTES + rrhc_pkg::HEADER_BYTES;
                v.f.first_address = addr[15:0];
                if (addr >= limit) begin
                    v.f.second_length = len;
                end else if (addr + 32'(len) > limit) begin
                    v.f.first_length = 16'(limit - addr);
                    v.f.second_length = len - v.f.first_length;
                end else begin
                    v.f.first_length = len;
                end
            end else begin
                v.action = rrhc_pkg::ACT_SKIPPED;
            end
            // every failure skips to the current page
            if (counts_error) begin
                nxt = hdr.current_page;
                if (errs_now != 16'hFFFF) errs_now = errs_now + 16'd1;
            end
            bytes_now = bytes_now + 32'(len);
            bnd_now = ((nxt == ring_start) ? ring_stop : nxt) - 8'd1;
        end
        v.f.packet_page = pg;
        v.f.payload_length = len;
        v.f.new_boundary = bnd_now;
        v.f.byte_total = bytes_now;
        v.f.error_total = errs_now;
        return v;
    endfunction

    // Draw a header that fits the ring as it now stands; mostly well-formed.
    function automatic rrhc_pkg::rx_item_t draw_header();
        rrhc_pkg::rx_item_t hdr;
        logic [7:0]         pg;
        int unsigned        pick;
        int unsigned        lo;
        int unsigned        len;
        pg = bnd_now + 8'd1;
        if (pg == ring_stop) pg = ring_start;
        pick = $urandom_range(99);
        hdr.current_page = 8'($urandom);
        hdr.header_status = 8'($urandom);
        hdr.header_next = 8'($urandom);
        hdr.header_count = 16'($urandom);
        hdr.max_length = 16'($urandom);
        if (pick < 6) return hdr;
        if (pick < 10) begin
            hdr.current_page = pg;
            return hdr;
        end
        if (hdr.current_page == pg) hdr.current_page = pg + 8'd1;
        lo = ring_min;
        if ($urandom_range(3) == 0) len = $urandom_range(65531, lo);
        else len = $urandom_range(lo + 300, lo);
        hdr.header_count = 16'(len + rrhc_pkg::HEADER_BYTES);
        hdr.max_length = 16'($urandom_range(65535, len));
        if (ring_start < ring_stop)
            hdr.header_next = 8'($urandom_range(ring_stop - 1, ring_start));
        hdr.header_status = (8'($urandom) & 8'hF6) | 8'h01;
        if (pick < 25) begin
            hdr.header_status = 8'($urandom) & 8'hF6;
        end else if (pick < 35) begin
            hdr.header_status = 8'($urandom) | 8'h08;
        end else if (pick < 45) begin
            case ($urandom_range(2))
                0: hdr.header_count = 16'($urandom_range(3));
                1: begin
                    if (len > 0) hdr.max_length = 16'($urandom_range(len - 1));
                    else hdr.header_count = 16'd2;
                end
                default: begin
                    if (lo > 0) hdr.header_count = 16'($urandom_range(lo + 3, 4));
                    else hdr.header_count = 16'd1;
                end
            endcase
        end else if (pick < 52) begin
            if (ring_start > 0 && $urandom_range(1) == 0)
                hdr.header_next = 8'($urandom_range(ring_start - 1, 0));
            else
                hdr.header_next = 8'($urandom_range(255, ring_stop));
        end
        return hdr;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            faults++;
            if (faults <= 10)
                $display("mismatch in %s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    task automatic send_header(input rrhc_pkg::rx_item_t hdr, input ring_verdict_t v);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= hdr;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        verdicts_due.push_back(v);
    endtask

    task automatic wait_ring_idle();
        s_tvalid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_ring(input logic [7:0] first_pg, input logic [7:0] end_pg,
                                input logic [10:0] min_len);
        wait_ring_idle();
        cfg_we <= 1'b1;
        cfg_index <= rrhc_pkg::CFG_START_PAGE;
        cfg_wdata <= 11'(first_pg);
        @(posedge aclk);
        cfg_index <= rrhc_pkg::CFG_STOP_PAGE;
        cfg_wdata <= 11'(end_pg);
        @(posedge aclk);
        cfg_index <= rrhc_pkg::CFG_MIN_LENGTH;
        cfg_wdata <= min_len;
        @(posedge aclk);
        cfg_we <= 1'b0;
        // the boundary is left as it was
        ring_start = first_pg;
        ring_stop = end_pg;
        ring_min = min_len;
    endtask

    task automatic stream_headers(input int n, input bit pause_midway);
        rrhc_pkg::rx_item_t hdr;
        ring_verdict_t      v;
        for (int i = 0; i < n; i++) begin
            if (pause_midway && i == n / 2) wait_ring_idle();
            hdr = draw_header();
            v = ring_step(hdr);
            send_header(hdr, v);
        end
    endtask

    // Receiver: check each transfer, then pick next cycle's tready.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen = m_tdata;
            if (verdicts_due.size() == 0) begin
                faults++;
                if (faults <= 10) $display("result transfer with nothing pending");
            end else begin
                due_now = verdicts_due.pop_front();
                check_field("action", 32'(due_now.action), 32'(m_tuser));
                check_field("packet_page", 32'(due_now.f.packet_page), 32'(seen.packet_page));
                check_field("payload_length", 32'(due_now.f.payload_length),
                            32'(seen.payload_length));
                check_field("first_address", 32'(due_now.f.first_address),
                            32'(seen.first_address));
                check_field("first_length", 32'(due_now.f.first_length),
                            32'(seen.first_length));
                check_field("second_length", 32'(due_now.f.second_length),
                            32'(seen.second_length));
                check_field("new_boundary", 32'(due_now.f.new_boundary),
                            32'(seen.new_boundary));
                check_field("byte_total", due_now.f.byte_total, seen.byte_total);
                check_field("error_total", 32'(due_now.f.error_total), 32'(seen.error_total));
            end
        end
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial begin
        rrhc_pkg::rx_item_t hdr;
        ring_verdict_t      v;
        ring_start = rrhc_pkg::START_PAGE_RST;
        ring_stop = rrhc_pkg::STOP_PAGE_RST;
        ring_min = rrhc_pkg::MIN_LENGTH_RST;
        bnd_now = rrhc_pkg::BOUNDARY_RST;
        bytes_now = '0;
        errs_now = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // untyped rows rely on the predictor alone
        foreach (directed_rows[i]) begin
            hdr = '{max_length: directed_rows[i].maxlen, header_count: directed_rows[i].count,
                    header_next: directed_rows[i].nxt, header_status: directed_rows[i].status,
                    current_page: directed_rows[i].cur};
            v = ring_step(hdr);
            if (directed_rows[i].typed) begin
                v.action = directed_rows[i].act;
                v.f.packet_page = directed_rows[i].page;
                v.f.new_boundary = directed_rows[i].bnd;
            end
            send_header(hdr, v);
        end

        stream_headers(250, 1'b0);

        program_ring(8'd0, 8'd255, 11'd0);
        src_idle_pct = 58;
        stream_headers(300, 1'b0);

        // inverted ring: no next page can be in range
        program_ring(8'd255, 8'd1, 11'd1514);
        src_idle_pct = 0;
        sink_stall_pct = 58;
        stream_headers(200, 1'b0);

        // hold the result side off long enough to back up the input
        program_ring(8'd16, 8'd24, 11'd46);
        src_idle_pct = 17;
        sink_stall_pct = 17;
        hold_request = 200;
        stream_headers(400, 1'b1);

        program_ring(8'd64, 8'd128, 11'd60);
        src_idle_pct = 58;
        sink_stall_pct = 0;
        stream_headers(400, 1'b0);

        program_ring(8'd200, 8'd255, 11'd1);
        src_idle_pct = 0;
        stream_headers(450, 1'b0);

        wait_ring_idle();
        repeat (10) @(posedge aclk);
        if (faults == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
